### rtl/mips_load_store_unit_core_macros.svh
// Assertion helpers for the load/store unit checker.
`ifndef MIPS_LOAD_STORE_UNIT_CORE_MACROS_SVH
`define MIPS_LOAD_STORE_UNIT_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define MLSU_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication, disabled in reset
`define MLSU_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

### rtl/mlsu_pkg.sv
`timescale 1ns / 1ps
package mlsu_pkg;

  typedef enum logic [3:0] {
    OP_LB   = 4'd0,
    OP_LBU  = 4'd1,
    OP_LH   = 4'd2,
    OP_LHU  = 4'd3,
    OP_LW   = 4'd4,
    OP_LWL  = 4'd5,
    OP_LWR  = 4'd6,
    OP_SB   = 4'd7,
    OP_SH   = 4'd8,
    OP_SW   = 4'd9,
    OP_SWL  = 4'd10,
    OP_SWR  = 4'd11,
    OP_LWC2 = 4'd12,
    OP_SWC2 = 4'd13
  } op_t;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_BASE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_COPIES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXT_BASE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EXT_LENGTH = 3'd4;

  localparam logic [31:0] RAM_BASE_RST   = 32'd0;
  localparam logic [18:0] RAM_LENGTH_RST = 19'd262144;
  localparam logic [3:0]  RAM_COPIES_RST = 4'd4;
  localparam logic [31:0] EXT_BASE_RST   = 32'd0;
  localparam logic [31:0] EXT_LENGTH_RST = 32'd0;

  // kseg1 starts at 0xA0000000: top three bits 3'b101
  localparam logic [2:0] KSEG1_TOP = 3'b101;

  typedef struct packed {
    logic [3:0]         op;
    logic [31:0]        base;
    logic signed [15:0] offset;
    logic [31:0]        store_data;
  } req_t;

  typedef struct packed {
    logic [31:0] load_value;
    logic        fault;
    logic        direct;
    logic        external;
    logic [31:0] ext_address;
    logic        to_cop2;
    logic        invalidate;
    logic [15:0] invalidate_index;
  } rsp_t;

  // controller -> datapath stage enables
  typedef struct packed {
    logic capture;
    logic addr;
    logic check;
    logic merge;
  } cmd_t;

endpackage

### rtl/mlsu_ctrl.sv
`timescale 1ns / 1ps
module mlsu_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  output logic            done,
  output mlsu_pkg::cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ADDR  = 5'b00010,
    ST_CHECK = 5'b00100,
    ST_MERGE = 5'b01000,
    ST_RESP  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  // a new transaction may enter while the previous result is on the ports;
  // nothing is taken while reset is held
  assign busy   = rst || ((state != ST_IDLE) && (state != ST_RESP));
  assign accept = start && !busy;
  assign done   = (state == ST_RESP);

  assign cmd.capture = accept;
  assign cmd.addr    = (state == ST_ADDR);
  assign cmd.check   = (state == ST_CHECK);
  assign cmd.merge   = (state == ST_MERGE);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept) state_next = ST_ADDR;
      ST_ADDR:  state_next = ST_CHECK;
      ST_CHECK: state_next = ST_MERGE;
      ST_MERGE: state_next = ST_RESP;
      ST_RESP:  state_next = accept ? ST_ADDR : ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/mlsu_dpath.sv
`timescale 1ns / 1ps
module mlsu_dpath #(
  parameter int RAM_WORDS = 65536
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mlsu_pkg::cmd_t                       cmd,
  input  mlsu_pkg::req_t                       req,
  input  logic                                 cfg_write,
  input  logic [mlsu_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [31:0]                          cfg_data,
  output mlsu_pkg::rsp_t                       rsp
);

  localparam int IDX_W = $clog2(RAM_WORDS);

  // configuration
  logic [31:0] ram_base;
  logic [18:0] ram_length;
  logic [3:0]  ram_copies;
  logic [31:0] ext_base;
  logic [31:0] ext_length;
  logic [22:0] span;

  // capture stage
  logic [3:0]  op_q;
  logic [31:0] eff;
  logic [31:0] data_q;

  // address stage
  logic [31:0] pa;
  logic        ram_ge;
  logic [31:0] ram_off;
  logic        ext_ge;
  logic [31:0] ext_off;

  // check stage
  logic             in_ram_c;
  logic             in_ext_c;
  logic [18:0]      offs_c;
  logic [31:0]      idx_wide;
  logic [IDX_W-1:0] idx_c;
  logic             hit_ram;
  logic             hit_ext;
  logic [18:0]      offs_q;
  logic [IDX_W-1:0] idx_q;
  logic [31:0]      rdata;

  // merge stage
  logic [31:0] mem [RAM_WORDS];
  logic [1:0]  lane;
  logic [4:0]  bs;
  logic [4:0]  hs;
  logic [4:0]  lsh;
  logic [31:0] w_b;
  logic [31:0] w_h;
  logic [31:0] keep;
  logic        is_store;
  logic [31:0] ld;
  logic [31:0] nw;
  logic        mem_we;
  mlsu_pkg::rsp_t rsp_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      ram_base   <= mlsu_pkg::RAM_BASE_RST;
      ram_length <= mlsu_pkg::RAM_LENGTH_RST;
      ram_copies <= mlsu_pkg::RAM_COPIES_RST;
      ext_base   <= mlsu_pkg::EXT_BASE_RST;
      ext_length <= mlsu_pkg::EXT_LENGTH_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mlsu_pkg::CFG_RAM_BASE:   ram_base   <= cfg_data;
        mlsu_pkg::CFG_RAM_LENGTH: ram_length <= cfg_data[18:0];
        mlsu_pkg::CFG_RAM_COPIES: ram_copies <= cfg_data[3:0];
        mlsu_pkg::CFG_EXT_BASE:   ext_base   <= cfg_data;
        mlsu_pkg::CFG_EXT_LENGTH: ext_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // window size, first used in the check stage
  always_ff @(posedge clk) begin
    span <= {4'b0, ram_length} * {19'b0, ram_copies};
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= req.op;
      eff    <= req.base + {{16{req.offset[15]}}, req.offset};
      data_q <= req.store_data;
    end
  end

  // segment strip: addresses from 0xA0000000 up (kseg1 and above) lose 0xA0000000, everything else loses bit 31
  always_comb begin
    if (eff[31:29] >= mlsu_pkg::KSEG1_TOP) begin
      pa = {eff[31:29] - mlsu_pkg::KSEG1_TOP, eff[28:0]};
    end else begin
      pa = {1'b0, eff[30:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.addr) begin
      ram_ge  <= (pa >= ram_base);
      ram_off <= pa - ram_base;
      ext_ge  <= (pa >= ext_base);
      ext_off <= pa - ext_base;
    end
  end

  // pa < base + len  <=>  pa - base < len, once pa >= base
  always_comb begin
    in_ram_c = ram_ge && (ram_off < {9'b0, span});
    in_ext_c = (ext_length != 32'd0) && ext_ge && (ext_off < ext_length);
    offs_c   = ram_off[18:0] & (ram_length - 19'd1);
    idx_wide = {15'b0, offs_c[18:2]};
    idx_c    = idx_wide[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      hit_ram <= in_ram_c;
      hit_ext <= !in_ram_c && in_ext_c;
      offs_q  <= offs_c;
      idx_q   <= idx_c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      rdata <= mem[idx_c];
    end
    if (mem_we) begin
      mem[idx_q] <= nw;
    end
  end

  always_comb begin
    lane = offs_q[1:0];
    bs   = {lane, 3'b000};
    hs   = {lane[1], 4'b0000};
    lsh  = 5'd24 - bs;
    w_b  = rdata >> bs;
    w_h  = rdata >> hs;
    keep = (lane == 2'd3) ? 32'd0 : (32'hFFFF_FFFF << (bs + 5'd8));
    is_store = 1'b0;
    ld       = rdata;
    nw       = rdata;
    unique case (op_q)
      mlsu_pkg::OP_LB:   ld = {{24{w_b[7]}}, w_b[7:0]};
      mlsu_pkg::OP_LBU:  ld = {24'b0, w_b[7:0]};
      mlsu_pkg::OP_LH:   ld = {{16{w_h[15]}}, w_h[15:0]};
      mlsu_pkg::OP_LHU:  ld = {16'b0, w_h[15:0]};
      mlsu_pkg::OP_LWL:  ld = (data_q & ~(32'hFFFF_FFFF << lsh)) | (rdata << lsh);
      mlsu_pkg::OP_LWR:  ld = (rdata >> bs) | (data_q & ~(32'hFFFF_FFFF >> bs));
      mlsu_pkg::OP_SB: begin
        is_store = 1'b1;
        nw = (rdata & ~(32'h0000_00FF << bs)) | ({24'b0, data_q[7:0]} << bs);
      end
      mlsu_pkg::OP_SH: begin
        is_store = 1'b1;
        nw = (rdata & ~(32'h0000_FFFF << hs)) | ({16'b0, data_q[15:0]} << hs);
      end
      mlsu_pkg::OP_SW, mlsu_pkg::OP_SWC2: begin
        is_store = 1'b1;
        nw = data_q;
      end
      mlsu_pkg::OP_SWL: begin
        is_store = 1'b1;
        nw = (data_q >> lsh) | (rdata & keep);
      end
      mlsu_pkg::OP_SWR: begin
        is_store = 1'b1;
        nw = (data_q << bs) | (rdata & ~(32'hFFFF_FFFF << bs));
      end
      default: ld = rdata; // LW, LWC2 and unused codes
    endcase

    mem_we   = cmd.merge && hit_ram && is_store;
    rsp_next = '0;
    if (hit_ram) begin
      rsp_next.direct = 1'b1;
      if (is_store) begin
        rsp_next.invalidate       = 1'b1;
        rsp_next.invalidate_index = offs_q[17:2];
      end else begin
        rsp_next.load_value = ld;
        rsp_next.to_cop2    = (op_q == mlsu_pkg::OP_LWC2);
      end
    end else if (hit_ext) begin
      rsp_next.external    = 1'b1;
      rsp_next.ext_address = eff;
      rsp_next.to_cop2     = (op_q == mlsu_pkg::OP_LWC2);
    end else begin
      rsp_next.fault = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.merge) begin
      rsp <= rsp_next;
    end
  end

endmodule

### rtl/mips_load_store_unit_core.sv
`timescale 1ns / 1ps
// Load/store unit: one transaction is taken when start is high and busy is
// low, and its result appears on rsp with done high for exactly one cycle,
// in the RESP state that follows the ADDR, CHECK and MERGE states; the
// receiver cannot stall it. A new transaction can be taken in the cycle
// that shows the previous result, but not while the previous one is in
// ADDR, CHECK or MERGE. The four steps are address form and segment strip,
// window check with the RAM read issued, the registered read data merge
// with write-back, and the result cycle; the single-port word RAM and its
// registered read set this sequence. The RAM has no reset or clearing
// pass: read a word only after it has been written. Configuration writes
// take effect for any transaction accepted at the same edge or later.
module mips_load_store_unit_core #(
  parameter int RAM_WORDS = 65536
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  mlsu_pkg::req_t                 req,
  output logic                           done,
  output mlsu_pkg::rsp_t                 rsp,
  input  logic                           cfg_write,
  input  logic [mlsu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);

  mlsu_pkg::cmd_t cmd;

  mlsu_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  mlsu_dpath #(
    .RAM_WORDS (RAM_WORDS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req       (req),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rsp       (rsp)
  );

endmodule

### rtl/mlsu_checker.sv
`timescale 1ns / 1ps
`include "mips_load_store_unit_core_macros.svh"
module mlsu_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input mlsu_pkg::rsp_t rsp
);

  logic accept;
  assign accept = start && !busy;

  // every accepted transaction is followed by its result with done high
  `MLSU_ASSERT_IMP(a_latency, clk, rst, accept, ##4 done)

  // unit stays busy in the cycle after a transaction is taken
  `MLSU_ASSERT_NXT(a_busy_after_accept, clk, rst, accept, busy && !done)

  // exactly one outcome per result
  `MLSU_ASSERT_IMP(a_one_outcome, clk, rst, done, $onehot({rsp.fault, rsp.direct, rsp.external}))

  // an invalidate only comes from a RAM store, which returns no load data
  `MLSU_ASSERT_IMP(a_inval_store, clk, rst, done && rsp.invalidate, rsp.direct && (rsp.load_value == 32'd0))

  // only external accesses carry an address
  `MLSU_ASSERT_IMP(a_ext_addr, clk, rst, done && !rsp.external, rsp.ext_address == 32'd0)

endmodule

bind mips_load_store_unit_core mlsu_checker u_mlsu_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);
